// ===== design/abe_pkg.sv =====
package abe_pkg;

    localparam int WORD_BITS = 32;
    localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hffff_ffff;

    localparam logic [2:0] CMD_SET       = 3'd0;
    localparam logic [2:0] CMD_CLEAR     = 3'd1;
    localparam logic [2:0] CMD_SET_RUN   = 3'd2;
    localparam logic [2:0] CMD_CLEAR_RUN = 3'd3;
    localparam logic [2:0] CMD_TEST      = 3'd4;
    localparam logic [2:0] CMD_SCAN      = 3'd5;
    localparam logic [2:0] CMD_SCAN_SET  = 3'd6;

    localparam logic [10:0] BIT_COUNT_RESET = 11'd1024;

    typedef struct packed {
        logic                 found;
        logic [4:0]           offset;
        logic [WORD_BITS-1:0] run_mask;
    } t_find;

endpackage

// ===== design/allocation_bitmap_engine_core.sv =====
// Allocation bitmap engine.
// Commands arrive on the input channel (i_in_valid / o_in_ready) and each one
// returns exactly one result beat on the output channel (o_out_valid /
// i_out_ready). The bitmap lives in a single-port-read, single-port-write RAM
// of WORD_COUNT 32-bit words with a registered read.
// Set, clear and test work on a single word. Run and scan commands stream one
// word per cycle through the RAM, touching or searching up to 32 words at the
// reset bit count; runs write each word back after reading it. A refused
// command, or one that needs no RAM access, goes straight to its result.
// One command is worked on at a time; a new command is accepted as soon as
// the previous one has its result parked in the output register, even if the
// receiver has not yet taken it. A stalled receiver holds the result and
// blocks only the completion of the following command.
// Reset: the bit count returns to 1024 and a clearing pass writes zero to
// every word, one per cycle, before o_in_ready rises.
// The bit count register may be written at any time the block is idle.
module allocation_bitmap_engine_core
    import abe_pkg::*;
#(
    parameter int WORD_COUNT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_cmd,
    input  logic [9:0]  i_index,
    input  logic [10:0] i_count,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_status,
    output logic        o_bit_value,
    output logic [9:0]  o_position
);

    localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(WORD_COUNT - 1);
    localparam int CAP_SAT = (WORD_COUNT * 32 > 2047) ? 2047 : WORD_COUNT * 32;
    localparam logic [10:0] CAP = 11'(CAP_SAT);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_TEST  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [10:0] r_bit_count;
    logic [AW-1:0] r_clr_ptr, n_clr_ptr;
    logic        r_set, n_set;
    logic        r_mark, n_mark;
    logic [5:0]  r_cnt, n_cnt;
    logic [5:0]  r_first_word, n_first_word;
    logic [5:0]  r_last_word, n_last_word;
    logic [4:0]  r_lo_bit, n_lo_bit;
    logic [4:0]  r_hi_bit, n_hi_bit;
    logic [5:0]  r_rd_ptr, n_rd_ptr;
    logic        r_rd_more, n_rd_more;
    logic        r_dv, n_dv;
    logic [5:0]  r_dv_ptr, n_dv_ptr;
    logic        r_res_status, n_res_status;
    logic        r_res_bit, n_res_bit;
    logic [9:0]  r_res_pos, n_res_pos;
    logic        r_o_valid, n_o_valid;
    logic        r_o_status, n_o_status;
    logic        r_o_bit, n_o_bit;
    logic [9:0]  r_o_pos, n_o_pos;

    logic [10:0] size;
    logic [10:0] idx11;
    logic [11:0] end_raw;
    logic [10:0] end_c;
    logic [10:0] run_hi;
    logic [5:0]  words;
    logic        cnt_ok;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [4:0]           m_lo;
    logic [4:0]           m_hi;
    logic [WORD_BITS-1:0] run_mask;
    t_find                find;

    abe_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (AW'(r_rd_ptr)),
        .o_rdata (ram_rdata)
    );

    abe_find u_find (
        .i_word  (ram_rdata),
        .i_count (r_cnt),
        .o_find  (find)
    );

    assign size    = (r_bit_count > CAP) ? CAP : r_bit_count;
    assign idx11   = {1'b0, i_index};
    assign end_raw = {1'b0, idx11} + {1'b0, i_count};
    assign end_c   = (end_raw > {1'b0, size}) ? size : end_raw[10:0];
    assign run_hi  = end_c - 11'd1;
    assign words   = size[10:5];
    assign cnt_ok  = (i_count != 11'd0) && (i_count <= 11'd32);

    // Edge words of a run are only partly covered; inner words take all 32 bits.
    assign m_lo     = (r_dv_ptr == r_first_word) ? r_lo_bit : 5'd0;
    assign m_hi     = (r_dv_ptr == r_last_word) ? r_hi_bit : 5'd31;
    assign run_mask = (FULL_WORD << m_lo) & (FULL_WORD >> (5'd31 - m_hi));

    always_comb begin
        n_state      = r_state;
        n_clr_ptr    = r_clr_ptr;
        n_set        = r_set;
        n_mark       = r_mark;
        n_cnt        = r_cnt;
        n_first_word = r_first_word;
        n_last_word  = r_last_word;
        n_lo_bit     = r_lo_bit;
        n_hi_bit     = r_hi_bit;
        n_rd_ptr     = r_rd_ptr;
        n_rd_more    = r_rd_more;
        n_dv         = 1'b0;
        n_dv_ptr     = r_rd_ptr;
        n_res_status = r_res_status;
        n_res_bit    = r_res_bit;
        n_res_pos    = r_res_pos;
        n_o_valid    = r_o_valid && !i_out_ready;
        n_o_status   = r_o_status;
        n_o_bit      = r_o_bit;
        n_o_pos      = r_o_pos;
        ram_we       = 1'b0;
        ram_waddr    = AW'(r_dv_ptr);
        ram_wdata    = r_set ? (ram_rdata | run_mask) : (ram_rdata & ~run_mask);

        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_ptr;
                ram_wdata = '0;
                if (r_clr_ptr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_ptr = r_clr_ptr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_res_status = 1'b0;
                    n_res_bit    = 1'b0;
                    n_res_pos    = '0;
                    n_cnt        = i_count[5:0];
                    n_mark       = (i_cmd == CMD_SCAN_SET);
                    n_set        = (i_cmd == CMD_SET) || (i_cmd == CMD_SET_RUN);
                    n_rd_more    = 1'b1;
                    n_lo_bit     = i_index[4:0];
                    n_hi_bit     = i_index[4:0];
                    n_first_word = idx11[10:5];
                    n_last_word  = idx11[10:5];
                    n_rd_ptr     = idx11[10:5];
                    case (i_cmd)
                        CMD_SET, CMD_CLEAR: begin
                            if (idx11 < size) begin
                                n_state = ST_RUN;
                            end else begin
                                n_res_status = 1'b1;
                                n_state      = ST_DONE;
                            end
                        end
                        CMD_SET_RUN, CMD_CLEAR_RUN: begin
                            n_hi_bit    = run_hi[4:0];
                            n_last_word = run_hi[10:5];
                            n_state     = (end_c > idx11) ? ST_RUN : ST_DONE;
                        end
                        CMD_TEST: begin
                            if (idx11 < size) begin
                                n_state = ST_TEST;
                            end else begin
                                n_res_status = 1'b1;
                                n_state      = ST_DONE;
                            end
                        end
                        CMD_SCAN, CMD_SCAN_SET: begin
                            n_first_word = '0;
                            n_rd_ptr     = '0;
                            n_last_word  = words - 6'd1;
                            if (cnt_ok && (words != 6'd0)) begin
                                n_state = ST_SCAN;
                            end else begin
                                n_res_status = 1'b1;
                                n_state      = ST_DONE;
                            end
                        end
                        default: begin
                            n_res_status = 1'b1;
                            n_state      = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RUN, ST_SCAN, ST_TEST: begin
                // Reads stream ahead one word per cycle; the data returns in the next cycle.
                n_dv = r_rd_more;
                if (r_rd_more) begin
                    if (r_rd_ptr == r_last_word) begin
                        n_rd_more = 1'b0;
                    end else begin
                        n_rd_ptr = r_rd_ptr + 6'd1;
                    end
                end
                if (r_dv) begin
                    if (r_state == ST_RUN) begin
                        ram_we = 1'b1;
                        if (r_dv_ptr == r_last_word) begin
                            n_state = ST_DONE;
                        end
                    end else if (r_state == ST_TEST) begin
                        n_res_bit = ram_rdata[r_lo_bit];
                        n_state   = ST_DONE;
                    end else if (find.found) begin
                        ram_we    = r_mark;
                        ram_wdata = ram_rdata | find.run_mask;
                        n_res_pos = {r_dv_ptr[4:0], find.offset};
                        n_rd_more = 1'b0;
                        n_state   = ST_DONE;
                    end else if (r_dv_ptr == r_last_word) begin
                        n_res_status = 1'b1;
                        n_state      = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_bit    = r_res_bit;
                    n_o_pos    = r_res_pos;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_ptr   <= '0;
            r_bit_count <= BIT_COUNT_RESET;
            r_rd_more   <= 1'b0;
            r_dv        <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_ptr <= n_clr_ptr;
            r_rd_more <= n_rd_more;
            r_dv      <= n_dv;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                r_bit_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_set        <= n_set;
        r_mark       <= n_mark;
        r_cnt        <= n_cnt;
        r_first_word <= n_first_word;
        r_last_word  <= n_last_word;
        r_lo_bit     <= n_lo_bit;
        r_hi_bit     <= n_hi_bit;
        r_rd_ptr     <= n_rd_ptr;
        r_dv_ptr     <= n_dv_ptr;
        r_res_status <= n_res_status;
        r_res_bit    <= n_res_bit;
        r_res_pos    <= n_res_pos;
        r_o_status   <= n_o_status;
        r_o_bit      <= n_o_bit;
        r_o_pos      <= n_o_pos;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_status    = r_o_status;
    assign o_bit_value = r_o_bit;
    assign o_position  = r_o_pos;

`ifndef SYNTHESIS
    // An accepted command always leaves the idle state for work or completion.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != ST_IDLE))
        else $error("accepted command did not leave idle");

    // Read data is only marked valid for a read that was actually issued.
    a_dv_from_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> $past(r_rd_more))
        else $error("read data valid without an issued read");

    // A new result beat appears only out of the completion state.
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result appeared outside completion");
`endif

endmodule

// ===== design/abe_ram.sv =====
module abe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/abe_find.sv =====
module abe_find
    import abe_pkg::*;
(
    input  logic [WORD_BITS-1:0] i_word,
    input  logic [5:0]           i_count,
    output t_find                o_find
);

    logic [WORD_BITS-1:0] mask;
    t_find                res;

    // Walk from the top down so that the lowest free start position wins.
    always_comb begin
        mask = FULL_WORD >> (6'd32 - i_count);
        res  = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if ((7'(j) + 7'(i_count) <= 7'd32) && ((i_word & (mask << j)) == '0)) begin
                res.found    = 1'b1;
                res.offset   = 5'(j);
                res.run_mask = mask << j;
            end
        end
    end

    assign o_find = res;

endmodule
